// ===== rtl/assert_macros.svh =====
// Assertion macros for the verification files of the contrast normalizer.
// Depends on nothing; included by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define MMCN_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define MMCN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mmcn_pkg.sv =====
// Shared types and constants of the min-max contrast normalizer.
// Depends on nothing; used by every module of the block.
`default_nettype none

package mmcn_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int INTENSITY_BITS = 8;
    localparam int COUNT_BITS     = $clog2(INTENSITY_BITS + 1);

    localparam logic OP_MEASURE   = 1'b0;
    localparam logic OP_NORMALIZE = 1'b1;

    typedef struct packed {
        logic                   op;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   first;
    } in_item_t;

    typedef struct packed {
        logic [INTENSITY_BITS-1:0] intensity;
        logic                      no_range;
    } out_item_t;

    // Operands of one normalize job, captured at acceptance.
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] offset;
        logic [SAMPLE_BITS-1:0] span;
        logic                   no_range;
    } job_t;

    typedef struct packed {
        logic start;
        logic take;
    } div_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIVIDE
    } ctl_state_t;

endpackage

`default_nettype wire

// ===== rtl/minmax_contrast_normalizer.sv =====
// Top level of the min-max contrast normalizer: control, output register and submodules.
// Depends on mmcn_pkg, mmcn_tracker and mmcn_divider.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    s_data  (op, sample, first)
//   m_        out        m_valid/m_ready    m_data  (intensity, no_range)
//
// A measure transaction produces no result and leaves s_ready high.
// A normalize transaction has its result valid after these steps: offset and
// range are captured at the accepting edge, then the LOAD state loads the divider, eight
// divider steps give one quotient bit each and the quotient then moves to the output.
// s_ready is high only while the serial divider is free, so a normalize transaction
// holds off new ones until its quotient is handed over, longer while a result waits.
// The output register lets a new transaction be accepted while a result waits.
// Reset is synchronous and active low; it restores the min/max trackers.
`default_nettype none

module minmax_contrast_normalizer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mmcn_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mmcn_pkg::out_item_t m_data
);
    import mmcn_pkg::*;

    ctl_state_t                state_reg, state_next;
    logic                      m_valid_reg, m_valid_next;
    out_item_t                 m_data_reg, m_data_next;
    logic                      accept;
    logic                      meas_en, norm_en;
    job_t                      job;
    div_ctl_t                  div_ctl;
    logic                      div_done;
    logic [INTENSITY_BITS-1:0] div_quotient;

    assign accept  = s_valid && s_ready;
    assign meas_en = accept && (s_data.op == OP_MEASURE);
    assign norm_en = accept && (s_data.op == OP_NORMALIZE);

    mmcn_tracker u_tracker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .meas_en (meas_en),
        .norm_en (norm_en),
        .item    (s_data),
        .job     (job)
    );

    mmcn_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (div_ctl),
        .offset   (job.offset),
        .span     (job.span),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // The job register holds its operands until the quotient has left the
    // divider, because no new transaction is accepted before then.
    always_comb begin
        state_next    = state_reg;
        s_ready       = 1'b0;
        div_ctl.start = 1'b0;
        div_ctl.take  = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (norm_en) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                div_ctl.start = 1'b1;
                state_next    = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                // Hand the quotient over once the output register is free.
                if (div_done && (!m_valid_reg || m_ready)) begin
                    div_ctl.take         = 1'b1;
                    m_valid_next         = 1'b1;
                    m_data_next.intensity = div_quotient;
                    m_data_next.no_range  = job.no_range;
                    state_next           = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== rtl/mmcn_tracker.sv =====
// Running minimum/maximum tracker and normalize-job operand capture.
// Depends on mmcn_pkg.
`default_nettype none

module mmcn_tracker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              meas_en,
    input  logic              norm_en,
    input  mmcn_pkg::in_item_t item,
    output mmcn_pkg::job_t     job
);
    import mmcn_pkg::*;

    logic [SAMPLE_BITS-1:0] lowest_reg, lowest_next;
    logic [SAMPLE_BITS-1:0] highest_reg, highest_next;
    logic                   any_reg, any_next;
    job_t                   job_reg, job_next;
    logic [SAMPLE_BITS-1:0] diff_span, range_val, diff_off, off_val;

    always_comb begin
        lowest_next  = lowest_reg;
        highest_next = highest_reg;
        any_next     = any_reg;
        if (meas_en) begin
            if (item.first) begin
                lowest_next  = item.sample;
                highest_next = item.sample;
            end else begin
                if (item.sample < lowest_reg) begin
                    lowest_next = item.sample;
                end
                if (item.sample > highest_reg) begin
                    highest_next = item.sample;
                end
            end
            any_next = 1'b1;
        end
    end

    // Before any measurement the reset values give a range of one and an
    // offset of zero, so the divider naturally returns zero.
    always_comb begin
        diff_span = (highest_reg > lowest_reg) ? (highest_reg - lowest_reg) : '0;
        range_val = (diff_span == '0) ? SAMPLE_BITS'(1) : diff_span;
        diff_off  = (item.sample > lowest_reg) ? (item.sample - lowest_reg) : '0;
        off_val   = (diff_off > range_val) ? range_val : diff_off;
        job_next  = job_reg;
        if (norm_en) begin
            job_next.offset   = off_val;
            job_next.span     = range_val;
            job_next.no_range = !any_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lowest_reg  <= '1;
            highest_reg <= '0;
            any_reg     <= 1'b0;
        end else begin
            lowest_reg  <= lowest_next;
            highest_reg <= highest_next;
            any_reg     <= any_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
    end

    assign job = job_reg;

endmodule

`default_nettype wire

// ===== rtl/mmcn_divider.sv =====
// Bit-serial restoring divider: floor(offset * 255 / span), one quotient bit per cycle.
// Depends on mmcn_pkg.
`default_nettype none

module mmcn_divider (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  mmcn_pkg::div_ctl_t                    ctl,
    input  logic [mmcn_pkg::SAMPLE_BITS-1:0]      offset,
    input  logic [mmcn_pkg::SAMPLE_BITS-1:0]      span,
    output logic                                  done,
    output logic [mmcn_pkg::INTENSITY_BITS-1:0]   quotient
);
    import mmcn_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int IB = INTENSITY_BITS;
    localparam int NB = SB + IB;

    logic [SB-1:0]         rem_reg, rem_next;
    logic [IB-1:0]         low_reg, low_next;
    logic [SB-1:0]         div_reg, div_next;
    logic [IB-1:0]         quo_reg, quo_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic [NB-1:0]         product;
    logic [SB:0]           trial, diff;
    logic                  fits;

    // offset * 255 as offset * 256 - offset. Since offset <= span the
    // quotient fits in IB bits and the high part starts below the divisor.
    assign product = {offset, {IB{1'b0}}} - {{IB{1'b0}}, offset};
    assign trial   = {rem_reg, low_reg[IB-1]};
    assign diff    = trial - {1'b0, div_reg};
    assign fits    = trial >= {1'b0, div_reg};

    always_comb begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        div_next  = div_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (ctl.start) begin
            rem_next  = product[NB-1:IB];
            low_next  = product[IB-1:0];
            div_next  = span;
            quo_next  = '0;
            cnt_next  = COUNT_BITS'(IB);
            busy_next = 1'b1;
        end else if (busy_reg && cnt_reg != '0) begin
            rem_next = fits ? diff[SB-1:0] : trial[SB-1:0];
            low_next = {low_reg[IB-2:0], 1'b0};
            quo_next = {quo_reg[IB-2:0], fits};
            cnt_next = cnt_reg - COUNT_BITS'(1);
        end else if (ctl.take) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
    end

    assign done     = busy_reg && (cnt_reg == '0);
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/mmcn_checker.sv =====
// Port-level assertions for the contrast normalizer and their bind to the top level.
// Depends on mmcn_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module mmcn_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire mmcn_pkg::in_item_t  s_data,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire mmcn_pkg::out_item_t m_data
);
    import mmcn_pkg::*;

    `MMCN_ASSERT(a_result_holds, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result dropped or changed while stalled")
    `MMCN_ASSERT(a_flag_zero, aclk, aresetn, m_valid && m_data.no_range |-> m_data.intensity == '0, "no_range result with nonzero intensity")
    `MMCN_ASSERT(a_busy_after_norm, aclk, aresetn, s_valid && s_ready && s_data.op == OP_NORMALIZE |=> !s_ready, "new transaction accepted during a division")
    `MMCN_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid, "result valid right after reset")

endmodule

bind minmax_contrast_normalizer mmcn_checker u_mmcn_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the min-max contrast normalizer (voxel sample to byte).
// Depends on mmcn_pkg and minmax_contrast_normalizer; drives and checks the block
// only through its ports.

module tb_top;

    import mmcn_pkg::*;

    localparam int unsigned FULL_SCALE = 255;
    localparam int unsigned SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;
    // Cycles without any accepted transaction before the run is declared hung.
    localparam int          STALL_LIMIT = 2000;
    // Settle time after a drain; it leaves margin beyond a normalize transaction's result.
    localparam int          SETTLE_CYCLES = 16;
    localparam int          ITEMS_PER_PHASE = 100;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    // Voxels waiting to be offered, and byte results predicted but not yet seen.
    in_item_t  pending_voxels[$];
    out_item_t expected_bytes[$];

    // Private copy of the block's min/max tracker.
    logic [SAMPLE_BITS-1:0] track_min = SAMPLE_MAX[SAMPLE_BITS-1:0];
    logic [SAMPLE_BITS-1:0] track_max = '0;
    logic                   track_valid = 1'b0;

    int   send_idle_pct = 0;
    int   stall_pct = 0;
    int   mismatch_count = 0;
    int   quiet_cycles = 0;
    logic in_taken = 1'b0;

    minmax_contrast_normalizer i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 4 ns clock period; the first rising edge comes after the block's processes start.
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Updates the tracker for a measure transaction, or predicts the byte that a
    // normalize transaction must produce. The division is exact integer floor.
    task automatic predict_normalize(input in_item_t voxel);
        int unsigned span;
        int unsigned offset;
        out_item_t   result;
        if (voxel.op == OP_MEASURE) begin
            if (voxel.first || !track_valid) begin
                // The reset values make a first measure without the flag behave
                // like a restart, so both branches collapse into one here.
                track_min = voxel.first ? voxel.sample
                          : (voxel.sample < track_min ? voxel.sample : track_min);
                track_max = voxel.first ? voxel.sample
                          : (voxel.sample > track_max ? voxel.sample : track_max);
            end else begin
                if (voxel.sample < track_min) track_min = voxel.sample;
                if (voxel.sample > track_max) track_max = voxel.sample;
            end
            track_valid = 1'b1;
        end else begin
            result = '0;
            if (!track_valid) begin
                result.no_range = 1'b1;
            end else begin
                span = (track_max > track_min) ? track_max - track_min : 0;
                if (span < 1) span = 1;
                offset = (voxel.sample > track_min) ? voxel.sample - track_min : 0;
                if (offset > span) offset = span;
                result.intensity = INTENSITY_BITS'((offset * FULL_SCALE) / span);
            end
            expected_bytes.push_back(result);
        end
    endtask

    task automatic note_mismatch(input string what, input int unsigned want, input int unsigned got);
        if (mismatch_count < 10) begin
            $display("[%0t] mismatch in %s: expected %0d, got %0d", $realtime, what, want, got);
        end
        mismatch_count++;
    endtask

    // Monitor and scoreboard. Inputs change on the falling edge, so everything
    // read here is the value that the block saw at this rising edge.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn) begin
            in_taken = s_valid && s_ready;
            if (in_taken) begin
                predict_normalize(s_data);
            end
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    note_mismatch("unexpected result transaction (intensity)", 0, m_data.intensity);
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_data.intensity !== want.intensity) begin
                        note_mismatch("intensity", want.intensity, m_data.intensity);
                    end
                    if (m_data.no_range !== want.no_range) begin
                        note_mismatch("no_range", want.no_range, m_data.no_range);
                    end
                end
            end
            // Watchdog: any accepted transaction on either side counts as progress.
            if (in_taken || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("minmax_contrast_normalizer regression: fail");
                $finish;
            end
        end
    end

    // Driver. A new voxel is offered only once the previous one was accepted,
    // so valid and payload stay put while the block holds s_ready low.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || in_taken) begin
                if (pending_voxels.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    s_data  <= pending_voxels.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99, 0) >= stall_pct);
        end
    end

    function automatic void queue_voxel(input logic op, input int unsigned sample,
                                        input logic first);
        in_item_t voxel;
        voxel.op     = op;
        voxel.sample = sample[SAMPLE_BITS-1:0];
        voxel.first  = first;
        pending_voxels.push_back(voxel);
    endfunction

    // Random traffic. Most of it is a measure run that opens with the restart flag
    // followed by a normalize run around the measured window; the rest is noise.
    task automatic queue_random_voxels(input int count);
        int added;
        int base;
        int spread;
        int meas_len;
        int norm_len;
        int lo;
        int hi;
        added = 0;
        while (added < count) begin
            if ($urandom_range(9, 0) < 8) begin
                case ($urandom_range(3, 0))
                    0: begin
                        spread = 0;
                    end
                    1: begin
                        spread = $urandom_range(8, 1);
                    end
                    2: begin
                        spread = $urandom_range(4095, 9);
                    end
                    default: begin
                        spread = SAMPLE_MAX;
                    end
                endcase
                base = (spread == SAMPLE_MAX) ? 0 : $urandom_range(SAMPLE_MAX - spread, 0);
                meas_len = $urandom_range(8, 1);
                norm_len = $urandom_range(10, 1);
                for (int i = 0; i < meas_len; i++) begin
                    queue_voxel(OP_MEASURE, base + $urandom_range(spread, 0),
                                (i == 0) || ($urandom_range(9, 0) == 0));
                end
                // Reach a little past both ends to exercise the clamps.
                lo = base - spread / 4 - 2;
                hi = base + spread + spread / 4 + 2;
                if (lo < 0) lo = 0;
                if (hi > SAMPLE_MAX) hi = SAMPLE_MAX;
                for (int i = 0; i < norm_len; i++) begin
                    queue_voxel(OP_NORMALIZE,
                                ($urandom_range(7, 0) == 0) ? $urandom_range(SAMPLE_MAX, 0)
                                                            : $urandom_range(hi, lo),
                                1'($urandom_range(1, 0)));
                end
                added += meas_len + norm_len;
            end else begin
                for (int i = 0; i < 4; i++) begin
                    queue_voxel(1'($urandom_range(1, 0)), $urandom_range(SAMPLE_MAX, 0),
                                1'($urandom_range(1, 0)));
                end
                added += 4;
            end
        end
    endtask

    // Holds the sender back until everything queued has been accepted and every
    // predicted byte has come out, then lets the block settle.
    task automatic drain_block;
        while (pending_voxels.size() != 0 || s_valid) @(negedge aclk);
        while (expected_bytes.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Normalizing before anything was measured flags no_range.
        queue_voxel(OP_NORMALIZE, 0, 1'b0);
        queue_voxel(OP_NORMALIZE, SAMPLE_MAX, 1'b1);
        // First measure after reset without the restart flag, then flat data:
        // at the minimum gives 0, above gives 255, below is clamped to 0.
        queue_voxel(OP_MEASURE, 1000, 1'b0);
        queue_voxel(OP_NORMALIZE, 1000, 1'b0);
        queue_voxel(OP_NORMALIZE, 1001, 1'b0);
        queue_voxel(OP_NORMALIZE, 999, 1'b0);
        // Full 16-bit range.
        queue_voxel(OP_MEASURE, 0, 1'b1);
        queue_voxel(OP_MEASURE, SAMPLE_MAX, 1'b0);
        queue_voxel(OP_NORMALIZE, 0, 1'b0);
        queue_voxel(OP_NORMALIZE, SAMPLE_MAX, 1'b0);
        queue_voxel(OP_NORMALIZE, 16'h8000, 1'b0);
        queue_voxel(OP_NORMALIZE, 1, 1'b0);
        // Narrow window with samples below and above it.
        queue_voxel(OP_MEASURE, 100, 1'b1);
        queue_voxel(OP_MEASURE, 200, 1'b0);
        queue_voxel(OP_NORMALIZE, 50, 1'b0);
        queue_voxel(OP_NORMALIZE, 300, 1'b0);
        queue_voxel(OP_NORMALIZE, 150, 1'b1);
        // Measuring again after normalizing widens the window.
        queue_voxel(OP_MEASURE, 0, 1'b0);
        queue_voxel(OP_NORMALIZE, 150, 1'b0);
        // Flat data at the top of the range.
        queue_voxel(OP_MEASURE, SAMPLE_MAX, 1'b1);
        queue_voxel(OP_NORMALIZE, SAMPLE_MAX, 1'b0);
        queue_voxel(OP_NORMALIZE, 0, 1'b0);
        drain_block();

        // Idling phases: none, sender idle, receiver stalling, both.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 49;
                    stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct = 49;
                end
                default: begin
                    send_idle_pct = 35;
                    stall_pct = 35;
                end
            endcase
            queue_random_voxels(ITEMS_PER_PHASE);
            drain_block();
        end

        if (expected_bytes.size() != 0) begin
            note_mismatch("leftover expected results", 0, expected_bytes.size());
        end
        if (mismatch_count == 0) begin
            $display("minmax_contrast_normalizer regression: pass");
        end else begin
            $display("minmax_contrast_normalizer regression: fail");
        end
        $finish;
    end

endmodule
